// File: src/battery_level_estimator_defines.svh
// assertion macros for the battery level estimator
`ifndef BATTERY_LEVEL_ESTIMATOR_DEFINES_SVH
`define BATTERY_LEVEL_ESTIMATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BLE_ASSERT_HOLD(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("battery level estimator: check failed");

// next-cycle implication, checked out of reset
`define BLE_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("battery level estimator: check failed");

`endif

// File: src/ble_pkg.sv
// shared constants and types of the battery level estimator
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

    localparam int unsigned FILTER_LEN        = 8;
    localparam int unsigned SAMPLES_PER_GROUP = 10;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned MV_W     = 13;
    localparam int unsigned LEVEL_W  = 7;
    localparam int unsigned SAMPLE_MAX = 4095;

    localparam int unsigned GSUM_W  = $clog2(SAMPLES_PER_GROUP * SAMPLE_MAX + 1);
    localparam int unsigned TOTAL_W = $clog2(FILTER_LEN * SAMPLE_MAX + 1);
    localparam int unsigned CNT_W   = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
    localparam int unsigned POS_W   = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
    localparam int unsigned PRIME_W = $clog2(FILTER_LEN + 1);
    localparam int unsigned RING_TOTAL_MAX = FILTER_LEN * SAMPLE_MAX;

    // reciprocal multiply for the constant divisions
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned GROUP_RECIP =
        ((1 << RECIP_SHIFT) + SAMPLES_PER_GROUP - 1) / SAMPLES_PER_GROUP;
    localparam int unsigned RING_RECIP  =
        ((1 << RECIP_SHIFT) + FILTER_LEN - 1) / FILTER_LEN;
    localparam int unsigned GPROD_W = GSUM_W + RECIP_W;
    localparam int unsigned FPROD_W = TOTAL_W + RECIP_W;

    // percent division
    localparam int unsigned PCT_FULL = 100;
    localparam int unsigned REM_W    = 20;
    localparam int unsigned QBITS    = 7;
    localparam int unsigned QCNT_W   = 3;

    localparam int unsigned MIN_MV_RESET = 3300;
    localparam int unsigned MAX_MV_RESET = 4200;

    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_MV,
        CFG_MAX_MV
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_SCALE,
        ST_MAP,
        ST_DIVIDE,
        ST_EMIT
    } ble_state_t;

endpackage

`default_nettype wire

// File: src/battery_level_estimator.sv
// battery level estimator: group average, history ring in memory, percent mapping
// a mid-group item is taken without a stall and the block stays ready
// an item that closes a group stalls the input through FETCH and UPDATE while priming, else
// also through SCALE, MAP, the 7-step divider unless clamped, EMIT and any wait on a stalled result
// limits return to 3300 / 4200 mv on reset
// reset clears counters, totals and result valid; ring memory is gated by a priming count
`timescale 1ns / 1ps
`default_nettype none
`include "battery_level_estimator_defines.svh"

module battery_level_estimator
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [ble_pkg::SAMPLE_W-1:0]       sample_mv,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [ble_pkg::LEVEL_W-1:0]             level_percent,
    output logic [ble_pkg::SAMPLE_W-1:0]            filtered_mv,
    input  wire logic                               cfg_write,
    input  wire logic [ble_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ble_pkg::MV_W-1:0]           cfg_data
);

    ble_pkg::ble_state_t                state_reg, state_next;
    logic [ble_pkg::MV_W-1:0]           min_mv_reg, min_mv_next;
    logic [ble_pkg::MV_W-1:0]           max_mv_reg, max_mv_next;
    logic [ble_pkg::GSUM_W-1:0]         group_sum_reg, group_sum_next;
    logic [ble_pkg::CNT_W-1:0]          group_count_reg, group_count_next;
    logic [ble_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [ble_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [ble_pkg::PRIME_W-1:0]        primed_reg, primed_next;
    logic [ble_pkg::QCNT_W-1:0]         cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;

    logic [ble_pkg::GPROD_W-1:0]        gprod_reg, gprod_next;
    logic [ble_pkg::FPROD_W-1:0]        fprod_reg, fprod_next;
    logic [ble_pkg::SAMPLE_W-1:0]       filt_reg, filt_next;
    logic [ble_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [ble_pkg::MV_W-1:0]           div_reg, div_next;
    logic [ble_pkg::QBITS-1:0]          quot_reg, quot_next;
    logic [ble_pkg::LEVEL_W-1:0]        level_reg, level_next;
    logic [ble_pkg::SAMPLE_W-1:0]       filt_out_reg, filt_out_next;

    logic [ble_pkg::SAMPLE_W-1:0]       ring_mem [ble_pkg::FILTER_LEN];
    logic [ble_pkg::SAMPLE_W-1:0]       ring_rd_reg;
    logic                               ring_we;

    logic [ble_pkg::SAMPLE_W-1:0]       avg;
    logic [ble_pkg::SAMPLE_W-1:0]       old_entry;
    logic                               primed_full;
    logic [ble_pkg::GSUM_W-1:0]         sum_in;
    logic [ble_pkg::SAMPLE_W-1:0]       filt_val;
    logic [ble_pkg::MV_W-1:0]           volt;
    logic [ble_pkg::REM_W-1:0]          div_shift;
    logic                               in_take;

    assign avg         = gprod_reg[ble_pkg::RECIP_SHIFT +: ble_pkg::SAMPLE_W];
    assign filt_val    = fprod_reg[ble_pkg::RECIP_SHIFT +: ble_pkg::SAMPLE_W];
    assign volt        = {filt_val, 1'b0};
    assign primed_full = (primed_reg == ble_pkg::PRIME_W'(ble_pkg::FILTER_LEN));
    assign old_entry   = primed_full ? ring_rd_reg : '0;
    assign sum_in      = group_sum_reg + ble_pkg::GSUM_W'(sample_mv);
    assign div_shift   = ble_pkg::REM_W'(div_reg) << cnt_reg;
    assign in_take     = in_valid && !in_stall;
    assign ring_we     = (state_reg == ble_pkg::ST_UPDATE);

    assign out_valid     = out_valid_reg;
    assign level_percent = level_reg;
    assign filtered_mv   = filt_out_reg;

    always_comb
    begin
        state_next       = state_reg;
        min_mv_next      = min_mv_reg;
        max_mv_next      = max_mv_reg;
        group_sum_next   = group_sum_reg;
        group_count_next = group_count_reg;
        pos_next         = pos_reg;
        total_next       = total_reg;
        primed_next      = primed_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        gprod_next       = gprod_reg;
        fprod_next       = fprod_reg;
        filt_next        = filt_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        quot_next        = quot_reg;
        level_next       = level_reg;
        filt_out_next    = filt_out_reg;
        in_stall         = (state_reg != ble_pkg::ST_IDLE);

        if (cfg_write)
        begin
            case (cfg_index)
                ble_pkg::CFG_MIN_MV: min_mv_next = cfg_data;
                ble_pkg::CFG_MAX_MV: max_mv_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ble_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    group_sum_next = sum_in;
                    if (group_count_reg == ble_pkg::CNT_W'(ble_pkg::SAMPLES_PER_GROUP - 1))
                    begin
                        group_count_next = '0;
                        state_next       = ble_pkg::ST_FETCH;
                    end
                    else
                    begin
                        group_count_next = group_count_reg + 1'b1;
                    end
                end
            end
            ble_pkg::ST_FETCH:
            begin
                gprod_next     = ble_pkg::GPROD_W'(group_sum_reg)
                               * ble_pkg::GPROD_W'(ble_pkg::GROUP_RECIP);
                group_sum_next = '0;
                state_next     = ble_pkg::ST_UPDATE;
            end
            ble_pkg::ST_UPDATE:
            begin
                total_next = total_reg - ble_pkg::TOTAL_W'(old_entry)
                           + ble_pkg::TOTAL_W'(avg);
                if (pos_reg == ble_pkg::POS_W'(ble_pkg::FILTER_LEN - 1))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                if (primed_full)
                begin
                    state_next = ble_pkg::ST_SCALE;
                end
                else
                begin
                    primed_next = primed_reg + 1'b1;
                    state_next  = ble_pkg::ST_IDLE;
                end
            end
            ble_pkg::ST_SCALE:
            begin
                fprod_next = ble_pkg::FPROD_W'(total_reg)
                           * ble_pkg::FPROD_W'(ble_pkg::RING_RECIP);
                state_next = ble_pkg::ST_MAP;
            end
            ble_pkg::ST_MAP:
            begin
                filt_next = filt_val;
                if (volt < min_mv_reg)
                begin
                    quot_next  = '0;
                    state_next = ble_pkg::ST_EMIT;
                end
                else if (volt > max_mv_reg || max_mv_reg == min_mv_reg)
                begin
                    quot_next  = ble_pkg::QBITS'(ble_pkg::PCT_FULL);
                    state_next = ble_pkg::ST_EMIT;
                end
                else
                begin
                    rem_next   = ble_pkg::REM_W'(volt - min_mv_reg)
                               * ble_pkg::REM_W'(ble_pkg::PCT_FULL);
                    div_next   = max_mv_reg - min_mv_reg;
                    quot_next  = '0;
                    cnt_next   = ble_pkg::QCNT_W'(ble_pkg::QBITS - 1);
                    state_next = ble_pkg::ST_DIVIDE;
                end
            end
            ble_pkg::ST_DIVIDE:
            begin
                if (rem_reg >= div_shift)
                begin
                    rem_next           = rem_reg - div_shift;
                    quot_next[cnt_reg] = 1'b1;
                end
                if (cnt_reg == '0)
                begin
                    state_next = ble_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ble_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    level_next     = ble_pkg::LEVEL_W'(quot_reg);
                    filt_out_next  = filt_reg;
                    out_valid_next = 1'b1;
                    state_next     = ble_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ble_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ble_pkg::ST_IDLE;
            min_mv_reg      <= ble_pkg::MV_W'(ble_pkg::MIN_MV_RESET);
            max_mv_reg      <= ble_pkg::MV_W'(ble_pkg::MAX_MV_RESET);
            group_sum_reg   <= '0;
            group_count_reg <= '0;
            pos_reg         <= '0;
            total_reg       <= '0;
            primed_reg      <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            min_mv_reg      <= min_mv_next;
            max_mv_reg      <= max_mv_next;
            group_sum_reg   <= group_sum_next;
            group_count_reg <= group_count_next;
            pos_reg         <= pos_next;
            total_reg       <= total_next;
            primed_reg      <= primed_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gprod_reg    <= gprod_next;
        fprod_reg    <= fprod_next;
        filt_reg     <= filt_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        quot_reg     <= quot_next;
        level_reg    <= level_next;
        filt_out_reg <= filt_out_next;
    end

    // history ring, one write in UPDATE and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[pos_reg] <= avg;
        end
        ring_rd_reg <= ring_mem[pos_reg];
    end

    `BLE_ASSERT_HOLD(a_total_bound, 1'b1, total_reg <= ble_pkg::TOTAL_W'(ble_pkg::RING_TOTAL_MAX))
    `BLE_ASSERT_HOLD(a_div_invariant, state_reg == ble_pkg::ST_DIVIDE, rem_reg < ((ble_pkg::REM_W + 1)'(div_reg) << (cnt_reg + 4'd1)))
    `BLE_ASSERT_NEXT(a_emit_lands, state_reg == ble_pkg::ST_EMIT && (!out_valid_reg || !out_stall), out_valid_reg && state_reg == ble_pkg::ST_IDLE)
    `BLE_ASSERT_HOLD(a_level_range, out_valid_reg, level_reg <= ble_pkg::LEVEL_W'(ble_pkg::PCT_FULL))

endmodule

`default_nettype wire

// File: test/battery_level_checker.sv
// checker for the battery level estimator: tracks both channels, predicts and compares
`timescale 1ns / 1ps

module battery_level_checker
    import ble_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample_mv,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [LEVEL_W-1:0]  level_percent,
    input  logic [SAMPLE_W-1:0] filtered_mv,
    input  logic                cfg_write,
    input  cfg_reg_t            cfg_index,
    input  logic [MV_W-1:0]     cfg_data,
    output int                  error_count,
    output int                  pending_results
);

    typedef struct packed
    {
        logic [LEVEL_W-1:0]  level;
        logic [SAMPLE_W-1:0] mean_mv;
    } gauge_reading_t;

    gauge_reading_t readings_due[$];
    gauge_reading_t oldest;

    logic [MV_W-1:0]     min_mv;
    logic [MV_W-1:0]     max_mv;
    logic [GSUM_W-1:0]   group_sum;
    logic [CNT_W-1:0]    group_count;
    logic [SAMPLE_W-1:0] history [FILTER_LEN];
    logic [POS_W-1:0]    ring_pos;
    logic [TOTAL_W-1:0]  ring_total;
    logic [PRIME_W-1:0]  primed;

    int mismatch_count = 0;
    int due_count = 0;

    assign error_count = mismatch_count;
    assign pending_results = due_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [LEVEL_W-1:0] percent_of(input logic [MV_W-1:0] batt_mv);
        int v;
        int lo;
        int hi;
        v = batt_mv;
        lo = min_mv;
        hi = max_mv;
        if (v < lo)
            return '0;
        if (v > hi || hi == lo)
            return LEVEL_W'(PCT_FULL);
        return LEVEL_W'(((v - lo) * PCT_FULL) / (hi - lo));
    endfunction

    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] mv);
        logic [SAMPLE_W-1:0] group_avg;
        logic [SAMPLE_W-1:0] ring_mean;
        gauge_reading_t reading;
        group_sum = group_sum + mv;
        group_count = group_count + 1'b1;
        if (group_count < SAMPLES_PER_GROUP)
            return;
        group_avg = SAMPLE_W'(group_sum / SAMPLES_PER_GROUP);
        group_sum = '0;
        group_count = '0;
        ring_total = ring_total - history[ring_pos] + group_avg;
        history[ring_pos] = group_avg;
        ring_pos = (ring_pos == POS_W'(FILTER_LEN - 1)) ? '0 : ring_pos + 1'b1;
        // ring still filling, nothing to report yet
        if (primed < FILTER_LEN)
        begin
            primed = primed + 1'b1;
            return;
        end
        ring_mean = SAMPLE_W'(ring_total / FILTER_LEN);
        reading.level = percent_of({ring_mean, 1'b0});
        reading.mean_mv = ring_mean;
        readings_due.push_back(reading);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mv = MV_W'(MIN_MV_RESET);
            max_mv = MV_W'(MAX_MV_RESET);
            group_sum = '0;
            group_count = '0;
            ring_pos = '0;
            ring_total = '0;
            primed = '0;
            foreach (history[i])
                history[i] = '0;
            readings_due.delete();
            due_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MIN_MV: min_mv = cfg_data;
                    CFG_MAX_MV: max_mv = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                    report_mismatch($sformatf("result with nothing due: level %0d, mv %0d",
                                              level_percent, filtered_mv));
                else
                begin
                    oldest = readings_due.pop_front();
                    if (level_percent !== oldest.level)
                        report_mismatch($sformatf("level_percent %0d, predicted %0d",
                                                  level_percent, oldest.level));
                    if (filtered_mv !== oldest.mean_mv)
                        report_mismatch($sformatf("filtered_mv %0d, predicted %0d",
                                                  filtered_mv, oldest.mean_mv));
                end
            end
            if (in_valid && !in_stall)
                accumulate_sample(sample_mv);
            due_count = readings_due.size();
        end
    end

endmodule

// File: test/testbench.sv
// top of the battery level estimator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

    import ble_pkg::*;

    localparam int MV_LIMIT = 8190;
    localparam int QUIET_CYCLES = 20;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic [SAMPLE_W-1:0] sample_mv = '0;
    logic                out_stall = 1'b0;
    logic                cfg_write = 1'b0;
    cfg_reg_t            cfg_index = CFG_MIN_MV;
    logic [MV_W-1:0]     cfg_data = '0;

    wire                 in_stall;
    wire                 out_valid;
    wire [LEVEL_W-1:0]   level_percent;
    wire [SAMPLE_W-1:0]  filtered_mv;

    int error_count;
    int pending_results;

    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int lo_mv = MIN_MV_RESET;
    int hi_mv = MAX_MV_RESET;
    int last_level = 2048;

    battery_level_estimator uut (.*);

    battery_level_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side stalls on its own pattern: free, patchy or mostly blocked
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic int clip_sample(input int v);
        if (v < 0)
            return 0;
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        return v;
    endfunction

    task automatic send_sample(input int v);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        sample_mv <= SAMPLE_W'(v);
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        burst_left--;
    endtask

    // jitter below zero means each item is drawn over the full range
    task automatic send_group(input int level, input int jitter);
        for (int i = 0; i < SAMPLES_PER_GROUP; i++)
        begin
            if (jitter < 0)
                send_sample($urandom_range(0, SAMPLE_MAX));
            else
                send_sample(clip_sample(level + int'($urandom_range(0, 2 * jitter)) - jitter));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending_results != 0);
        @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input int lo, input int hi);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MIN_MV;
        cfg_data <= MV_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_MAX_MV;
        cfg_data <= MV_W'(hi);
        @(posedge clk);
        cfg_write <= 1'b0;
        lo_mv = lo;
        hi_mv = hi;
    endtask

    task automatic pick_limits();
        int kind;
        int lo;
        int hi;
        kind = $urandom_range(0, 5);
        case (kind)
            0:
            begin
                lo = MIN_MV_RESET;
                hi = MAX_MV_RESET;
            end
            1:
            begin
                lo = $urandom_range(0, 8000);
                hi = $urandom_range(lo + 1, MV_LIMIT);
            end
            2:
            begin
                lo = 0;
                hi = MV_LIMIT;
            end
            3:
            begin
                lo = 2 * $urandom_range(0, SAMPLE_MAX);
                hi = lo;
            end
            4:
            begin
                hi = $urandom_range(1, 8000);
                lo = $urandom_range(hi + 1, MV_LIMIT);
            end
            default:
            begin
                lo = $urandom_range(2000, 8100);
                hi = lo + $urandom_range(1, 90);
            end
        endcase
        write_limits(lo, hi);
    endtask

    // most groups sit inside the mapped band so the division gets exercised
    task automatic random_group();
        int kind;
        int lowb;
        int highb;
        kind = $urandom_range(0, 9);
        lowb = clip_sample(((lo_mv < hi_mv) ? lo_mv : hi_mv) / 2);
        highb = clip_sample(((lo_mv < hi_mv) ? hi_mv : lo_mv) / 2);
        if (kind < 5)
        begin
            last_level = $urandom_range(lowb, highb);
            send_group(last_level, $urandom_range(0, 60));
        end
        else if (kind < 7)
            send_group(0, -1);
        else if (kind == 7)
        begin
            for (int i = 0; i < SAMPLES_PER_GROUP; i++)
                send_sample(($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0);
        end
        else
            send_group(last_level, $urandom_range(0, 5));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ring fill: first group swings every bit of the item
        for (int i = 0; i < SAMPLES_PER_GROUP; i++)
            send_sample((i % 2 == 1) ? SAMPLE_MAX : 0);
        repeat (FILTER_LEN - 1) send_group(2100, 0);
        send_group(1650, 0);
        send_group(SAMPLE_MAX, 0);
        send_group(0, 0);
        send_group(2100, 30);

        // equal limits, ring settles on exactly the limit
        drain();
        write_limits(4200, 4200);
        repeat (FILTER_LEN) send_group(2100, 0);

        // inverted limits, min at the highest voltage 8190 and max at 1
        drain();
        write_limits(MV_LIMIT, 1);
        repeat (FILTER_LEN) send_group(SAMPLE_MAX, 0);
        send_group(0, 0);

        // widest band
        drain();
        write_limits(0, MV_LIMIT);
        send_group(1000, 500);
        send_group(3000, 500);
        send_group(SAMPLE_MAX, 0);
        send_group(0, -1);

        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            pick_limits();
            for (int g = 0; g < 14; g++)
            begin
                random_group();
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
        end

        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
